// File: rtl/cbts_pkg.sv
// Shared types, constants and the segment split function of the CAN bit timing solver.
package cbts_pkg;

   localparam int CLK_W       = 32;
   localparam int RATE_W      = 24;
   localparam int STAT_W      = 2;
   localparam int PRESC_W     = 8;
   localparam int SEG_W       = 3;
   localparam int WORD_W      = 32;
   localparam int QUANTA_W    = 5;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 56;

   localparam int PRESCALE_MAX_DEF = 256;
   // The prescaler field is 8 bits wide, so nothing above this can be encoded.
   localparam int PRESC_ENC_MAX    = 256;

   localparam int TQ_LOW   = 16;
   localparam int TQ_HIGH  = 25;
   localparam int SEG_LOW  = 1;
   localparam int SEG_HIGH = 8;

   // Phase segment 1 is round(rest * 64 / 73).
   localparam int PH1_NUM = 64;
   localparam int PH1_DEN = 73;
   localparam int PH1_RND = 36;

   // Restoring divider: one quotient bit per step.
   localparam int DIV_STEPS = CLK_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [STAT_W-1:0] {
      STAT_OK           = 2'd0,
      STAT_INVALID      = 2'd1,
      STAT_NOT_MULTIPLE = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       srch_step;
      logic       emit;
      status_type emit_status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rate_zero;
      logic div_done;
      logic rem_nonzero;
      logic match;
      logic brp_last;
   } sts_type;

   // Segment split of one quanta count, fields coded as length minus one.
   typedef struct packed {
      logic             valid;
      logic [SEG_W-1:0] prop;
      logic [SEG_W-1:0] ph1;
      logic [SEG_W-1:0] ph2;
   } seg_type;

   function automatic seg_type seg_split(input logic [QUANTA_W-1:0] quanta);
      seg_type             res;
      logic [QUANTA_W-1:0] rest;
      logic [10:0]         num;
      logic [QUANTA_W-1:0] p1;
      logic [QUANTA_W-1:0] pr;
      logic [QUANTA_W-1:0] p2;
      res.valid = 1'b1;
      rest = quanta - QUANTA_W'(1);
      num  = 11'(rest) * 11'(PH1_NUM) + 11'(PH1_RND);
      p1   = QUANTA_W'(num / 11'(PH1_DEN));
      pr   = QUANTA_W'(SEG_LOW);
      if (p1 > QUANTA_W'(SEG_HIGH)) begin
         pr = p1 - QUANTA_W'(SEG_HIGH);
         p1 = QUANTA_W'(SEG_HIGH);
      end
      p2 = rest - pr - p1;
      if (quanta < QUANTA_W'(TQ_LOW) || quanta > QUANTA_W'(TQ_HIGH)) begin
         res.valid = 1'b0;
      end
      if (pr > QUANTA_W'(SEG_HIGH)) begin
         res.valid = 1'b0;
      end
      if (pr + p1 >= rest) begin
         res.valid = 1'b0;
      end
      if (p1 < QUANTA_W'(SEG_LOW)) begin
         res.valid = 1'b0;
      end
      if (p2 < QUANTA_W'(SEG_LOW) || p2 > QUANTA_W'(SEG_HIGH)) begin
         res.valid = 1'b0;
      end
      res.prop = SEG_W'(pr - QUANTA_W'(1));
      res.ph1  = SEG_W'(p1 - QUANTA_W'(1));
      res.ph2  = SEG_W'(p2 - QUANTA_W'(1));
      return res;
   endfunction

endpackage

// File: rtl/cbts_ctrl.sv
// Controller state machine of the CAN bit timing solver.
module cbts_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output cbts_pkg::cmd_type cmd,
   input  cbts_pkg::sts_type sts
);
   import cbts_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in        = state_ff;
      status_in       = status_ff;
      cmd             = '0;
      cmd.emit_status = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            priority if (sts.rate_zero) begin
               status_in = STAT_INVALID;
               state_in  = ST_DONE;
            end else if (sts.div_done && sts.rem_nonzero) begin
               status_in = STAT_NOT_MULTIPLE;
               state_in  = ST_DONE;
            end else if (sts.div_done) begin
               state_in = ST_SEARCH;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_SEARCH: begin
            priority if (sts.match) begin
               status_in = STAT_OK;
               state_in  = ST_DONE;
            end else if (sts.brp_last) begin
               status_in = STAT_INVALID;
               state_in  = ST_DONE;
            end else begin
               cmd.srch_step = 1'b1;
            end
         end
         ST_DONE: begin
            // The result leaves as soon as the output register can take it.
            if (slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         status_ff    <= STAT_INVALID;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A new result never overwrites one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // The search starts only after a clean division by a nonzero bitrate.
   a_search_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && state_in == ST_SEARCH)
         |-> (sts.div_done && !sts.rem_nonzero && !sts.rate_zero))
      else $error("search entered without a valid quotient");

   // A success result is held only while the datapath still sees the match.
   a_ok_has_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && status_ff == STAT_OK) |-> sts.match)
      else $error("success status without a matching prescaler");

endmodule

// File: rtl/cbts_dpath.sv
// Datapath of the CAN bit timing solver: serial divider, prescaler search, result register.
module cbts_dpath #(
   parameter int PRESCALE_MAX = cbts_pkg::PRESCALE_MAX_DEF
) (
   input  logic                             clock,
   input  logic [cbts_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic [cbts_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  cbts_pkg::cmd_type                cmd,
   output cbts_pkg::sts_type                sts
);
   import cbts_pkg::*;

   localparam int PRESC_LIMIT = (PRESCALE_MAX < PRESC_ENC_MAX) ? PRESCALE_MAX : PRESC_ENC_MAX;
   localparam int BRP_W       = $clog2(PRESC_LIMIT + 1);
   localparam int PROD_W      = BRP_W + QUANTA_W;
   localparam int PAD_W       = RSP_TDATA_W - (STAT_W + PRESC_W + 3 * SEG_W + WORD_W);
   localparam int GAP_W       = WORD_W - (PRESC_W + 2 + 3 * SEG_W);

   logic [CLK_W-1:0]       quo_ff, quo_in;
   logic [RATE_W-1:0]      rem_ff, rem_in;
   logic [RATE_W-1:0]      rate_ff, rate_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [BRP_W-1:0]       brp_ff, brp_in;
   logic [RSP_TDATA_W-1:0] rsp_ff, rsp_in;

   logic [RATE_W:0]        shifted;
   logic [RATE_W:0]        diff;
   logic                   match;
   seg_type                seg_hit;

   // One restoring division step: the quotient register shifts the dividend out
   // and the quotient bits in.
   assign shifted = {rem_ff, quo_ff[CLK_W-1]};
   assign diff    = shifted - {1'b0, rate_ff};

   // Compare the quotient with the current prescaler times every quanta count.
   always_comb begin : search_blk
      logic [PROD_W-1:0] prod;
      seg_type           seg;
      match   = 1'b0;
      seg_hit = '0;
      for (int q = TQ_LOW; q <= TQ_HIGH; q++) begin
         prod = PROD_W'(brp_ff) * PROD_W'(q);
         seg  = seg_split(QUANTA_W'(q));
         if (seg.valid && quo_ff == CLK_W'(prod)) begin
            match   = 1'b1;
            seg_hit = seg;
         end
      end
   end

   assign sts.rate_zero   = (rate_ff == '0);
   assign sts.div_done    = (cnt_ff == DIV_CNT_W'(DIV_STEPS));
   assign sts.rem_nonzero = (rem_ff != '0);
   assign sts.match       = match;
   assign sts.brp_last    = (brp_ff == BRP_W'(PRESC_LIMIT));

   always_comb begin : next_blk
      logic [PRESC_W-1:0] presc;
      logic [WORD_W-1:0]  word;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      rate_in = rate_ff;
      cnt_in  = cnt_ff;
      brp_in  = brp_ff;
      rsp_in  = rsp_ff;
      presc   = PRESC_W'(brp_ff - BRP_W'(1));
      word    = {presc, 2'b00, seg_hit.ph1, seg_hit.ph2, {GAP_W{1'b0}}, seg_hit.prop};
      if (cmd.load) begin
         quo_in  = req_tdata[CLK_W-1:0];
         rate_in = req_tdata[CLK_W +: RATE_W];
         rem_in  = '0;
         cnt_in  = '0;
         brp_in  = BRP_W'(1);
      end
      if (cmd.div_step) begin
         if (!diff[RATE_W]) begin
            rem_in = diff[RATE_W-1:0];
            quo_in = {quo_ff[CLK_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[RATE_W-1:0];
            quo_in = {quo_ff[CLK_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.srch_step) begin
         brp_in = brp_ff + BRP_W'(1);
      end
      if (cmd.emit) begin
         if (cmd.emit_status == STAT_OK) begin
            rsp_in = {{PAD_W{1'b0}}, word, seg_hit.ph2, seg_hit.ph1, seg_hit.prop,
                      presc, cmd.emit_status};
         end else begin
            rsp_in = {{(RSP_TDATA_W - STAT_W){1'b0}}, cmd.emit_status};
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      rate_ff <= rate_in;
      cnt_ff  <= cnt_in;
      brp_ff  <= brp_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_tdata = rsp_ff;

endmodule

// File: rtl/can_bit_timing_solver.sv
// Top level of the CAN bit timing solver.
//
// The solver takes one request holding a module clock frequency and a wanted CAN
// bitrate and returns one result with a prescaler and a propagation, phase 1 and
// phase 2 split whose time quanta give the bitrate exactly. A zero bitrate returns
// status 1, a clock that is not a whole multiple of the bitrate returns status 2,
// and a search that finds no prescaler returns status 1; on any error all other
// fields and the timing word are zero. One request is worked on at a time. It is
// accepted, then the bit-serial divider forms the clock over bitrate quotient
// (a zero bitrate is rejected right after the accept, before the divider runs),
// then prescalers are tried in turn starting at 1, up to min(PRESCALE_MAX, 256),
// and last the result is moved to the output register. A result that waits at
// the output does not block the next request from being accepted; the following
// result waits until the first is taken.
module can_bit_timing_solver #(
   parameter int PRESCALE_MAX = cbts_pkg::PRESCALE_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request: clock_freq [31:0], bitrate [55:32].
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cbts_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Result: status [1:0], prescale_field [9:2], propagation_field [12:10],
   // phase_one_field [15:13], phase_two_field [18:16], timing_word [50:19],
   // zero padding [55:51].
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cbts_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import cbts_pkg::*;

   // Commands and status between the controller and the datapath.
   cmd_type cmd;
   sts_type sts;

   // The controller sequences accept, division, search and result hand-off.
   cbts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath holds the divider, the prescaler counter and the result register.
   cbts_dpath #(
      .PRESCALE_MAX (PRESCALE_MAX)
   ) u_dpath (
      .clock     (clock),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// File: dv/tb.sv
// Self-checking testbench for the CAN bit timing solver.
`timescale 1ns / 1ps

module tb;
   import cbts_pkg::*;

   // The run is cut off here if it has not ended by itself. The limit allows for the
   // slowest correct request, a sender gap and a result stall, for each of roughly
   // 1030 requests, with a wide margin.
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   // Cycles to wait after the last result. This is a little more than the longest
   // prescaler scan.
   localparam int unsigned TAIL_CYCLES = 400;
   // The search never goes past what the 8-bit prescaler field can hold.
   localparam int unsigned SEARCH_MAX =
      (PRESCALE_MAX_DEF < PRESC_ENC_MAX) ? PRESCALE_MAX_DEF : PRESC_ENC_MAX;
   localparam int unsigned RANDOM_ITEMS = 1000;
   // Percent of cycles, or of requests, in which a side idles.
   localparam int unsigned IDLE_PCT = 7;

   // One bit timing answer, with each field at the width that it has in the result.
   typedef struct packed {
      status_type         status;
      logic [PRESC_W-1:0] prescale;
      logic [SEG_W-1:0]   prop;
      logic [SEG_W-1:0]   ph1;
      logic [SEG_W-1:0]   ph2;
      logic [WORD_W-1:0]  word;
   } timing_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // Request: clock_freq [31:0], bitrate [55:32].
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // Result: status [1:0], prescale_field [9:2], propagation_field [12:10],
   // phase_one_field [15:13], phase_two_field [18:16], timing_word [50:19],
   // zero padding [55:51].
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Answers that are owed for accepted requests, the oldest first.
   timing_type  pending_timing[$];
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   // While set, neither side starts a new idle stretch.
   bit          quiet = 1'b0;
   int unsigned rsp_stall_left = 0;

   can_bit_timing_solver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Works out the answer for one request. A zero bitrate and a clock that is not
   // a whole multiple of the bitrate are rejected up front. Otherwise the first
   // prescaler whose quanta count lands in 16..25 and splits into legal segments
   // wins. Phase 1 is the rounded 64/73 share of the quanta after sync, with any
   // excess over 8 moved into the propagation segment.
   function automatic timing_type solve_timing(input logic [CLK_W-1:0] clk_hz,
                                               input logic [RATE_W-1:0] rate);
      timing_type  res;
      logic [63:0] divisor;
      logic [63:0] quanta;
      int unsigned rest;
      int unsigned p1;
      int unsigned pr;
      int unsigned p2;
      res = '0;
      res.status = STAT_INVALID;
      if (rate == '0) begin
         return res;
      end
      if ((64'(clk_hz) % 64'(rate)) != 64'd0) begin
         res.status = STAT_NOT_MULTIPLE;
         return res;
      end
      for (int unsigned brp = 1; brp <= SEARCH_MAX; brp++) begin
         divisor = 64'(brp) * 64'(rate);
         if ((64'(clk_hz) % divisor) == 64'd0) begin
            quanta = 64'(clk_hz) / divisor;
            if (quanta >= 64'(TQ_LOW) && quanta <= 64'(TQ_HIGH)) begin
               rest = int'(quanta) - 1;
               p1   = (rest * PH1_NUM + PH1_RND) / PH1_DEN;
               pr   = SEG_LOW;
               if (p1 > SEG_HIGH) begin
                  pr = p1 - SEG_HIGH;
                  p1 = SEG_HIGH;
               end
               if (pr <= SEG_HIGH && pr + p1 < rest && p1 >= SEG_LOW) begin
                  p2 = rest - pr - p1;
                  if (p2 >= SEG_LOW && p2 <= SEG_HIGH) begin
                     res.status   = STAT_OK;
                     res.prescale = PRESC_W'(brp - 1);
                     res.prop     = SEG_W'(pr - 1);
                     res.ph1      = SEG_W'(p1 - 1);
                     res.ph2      = SEG_W'(p2 - 1);
                     // The resync jump width bits [23:22] stay zero.
                     res.word     = {res.prescale, 2'b00, res.ph1, res.ph2, 13'd0,
                                     res.prop};
                     return res;
                  end
               end
            end
         end
      end
      return res;
   endfunction

   // Offers one request and returns at the falling edge after it is accepted, with
   // tvalid still high, so that back-to-back requests never drop tvalid in between.
   // Now and then the sender goes quiet for a while first.
   task automatic send_request(input logic [CLK_W-1:0] clk_hz,
                               input logic [RATE_W-1:0] rate);
      if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 300)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rate, clk_hz};
      do begin
         @(posedge clock);
      end while (!req_tready);
      pending_timing.push_back(solve_timing(clk_hz, rate));
      @(negedge clock);
   endtask

   // Ends a group of requests: drops tvalid and waits until every answer is in.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_timing.size() != 0) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Rejected requests and the edges of both fields.
   task automatic test_rejects();
      send_request(32'd80_000_000, 24'd0);
      send_request(32'hFFFF_FFFF, 24'd0);
      send_request(32'd0, 24'd500_000);
      send_request(32'd0, 24'hFF_FFFF);
      send_request(32'd80_000_001, 24'd500_000);
      send_request(32'hFFFF_FFFF, 24'hFF_FFFF);
      send_request(32'd1, 24'd1);
      drain_results();
   endtask

   // Quanta counts around the legal window, the prescaler search order and the
   // top of the prescaler range.
   task automatic test_prescaler_search();
      for (int unsigned q = 14; q <= 27; q++) begin
         send_request(CLK_W'(q * 1_000_000), 24'd1_000_000);
      end
      // The largest bitrate with the smallest prescaler and 16 quanta.
      send_request(32'h0FFF_FFF0, 24'hFF_FFFF);
      // 160 quanta per bit: prescaler 8 gives 20 quanta, which cannot be split,
      // so the search has to go on to prescaler 10.
      send_request(32'd80_000_000, 24'd500_000);
      // Only prescaler 256 fits.
      send_request(32'd4096, 24'd1);
      // Only prescaler 257 would fit, which is out of range.
      send_request(32'd4112, 24'd1);
      drain_results();
   endtask

   // Mostly requests that are built to be solvable or nearly so, mixed with raw
   // noise. A stretch in the middle runs with no new idling started on either side.
   task automatic test_random_requests();
      int unsigned     brp;
      int unsigned     q;
      int unsigned     lim;
      logic [RATE_W-1:0] rate;
      logic [CLK_W-1:0]  clk_hz;
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         quiet = (n >= 300 && n < 500);
         if ($urandom_range(0, 99) < 75) begin
            // Prescaler times quanta times bitrate, so the clock is a multiple.
            brp = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 16)
                                               : $urandom_range(1, 256);
            q   = $urandom_range(14, 27);
            lim = 32'hFFFF_FFFF / (brp * q);
            if (lim > 32'h00FF_FFFF) begin
               lim = 32'h00FF_FFFF;
            end
            rate   = RATE_W'($urandom_range(1, lim));
            clk_hz = CLK_W'(brp * q * rate);
         end else begin
            case ($urandom_range(0, 3))
               0, 1: begin
                  rate   = RATE_W'($urandom());
                  clk_hz = $urandom();
               end
               2: begin
                  rate   = RATE_W'($urandom_range(1, 32'h00FF_FFFF));
                  clk_hz = CLK_W'(rate * $urandom_range(0, 32'hFFFF_FFFF / rate));
               end
               default: begin
                  rate   = RATE_W'($urandom_range(0, 3));
                  clk_hz = $urandom();
               end
            endcase
         end
         send_request(clk_hz, rate);
      end
      quiet = 1'b0;
      drain_results();
   endtask

   // The result side stalls now and then, sometimes for a burst of cycles.
   always @(negedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_tready     <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         rsp_stall_left <= $urandom_range(0, 20);
         rsp_tready     <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every accepted result is matched against the oldest answer that is owed.
   always @(posedge clock) begin
      timing_type owed;
      timing_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = status_type'(rsp_tdata[1:0]);
         got.prescale = rsp_tdata[9:2];
         got.prop     = rsp_tdata[12:10];
         got.ph1      = rsp_tdata[15:13];
         got.ph2      = rsp_tdata[18:16];
         got.word     = rsp_tdata[50:19];
         if (pending_timing.size() == 0) begin
            $error("result with no request outstanding: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            owed = pending_timing.pop_front();
            if (got.status != owed.status) begin
               $error("status: expected %0d, got %0d", owed.status, got.status);
               fail_count++;
            end
            if (got.prescale != owed.prescale) begin
               $error("prescale_field: expected %0d, got %0d", owed.prescale,
                      got.prescale);
               fail_count++;
            end
            if (got.prop != owed.prop) begin
               $error("propagation_field: expected %0d, got %0d", owed.prop, got.prop);
               fail_count++;
            end
            if (got.ph1 != owed.ph1) begin
               $error("phase_one_field: expected %0d, got %0d", owed.ph1, got.ph1);
               fail_count++;
            end
            if (got.ph2 != owed.ph2) begin
               $error("phase_two_field: expected %0d, got %0d", owed.ph2, got.ph2);
               fail_count++;
            end
            if (got.word != owed.word) begin
               $error("timing_word: expected %h, got %h", owed.word, got.word);
               fail_count++;
            end
            if (rsp_tdata[55:51] != '0) begin
               $error("padding: expected %h, got %h", 5'd0, rsp_tdata[55:51]);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("can_bit_timing_solver test failed");
         $finish;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_rejects();
      test_prescaler_search();
      test_random_requests();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_timing.size() == 0) begin
         $display("can_bit_timing_solver test passed");
      end else begin
         if (pending_timing.size() != 0) begin
            $error("%0d results never arrived", pending_timing.size());
         end
         $display("can_bit_timing_solver test failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/cbts_pkg.sv
rtl/cbts_ctrl.sv
rtl/cbts_dpath.sv
rtl/can_bit_timing_solver.sv
dv/tb.sv
